// ----- rtl/rwc_pkg.sv -----
// Shared types and constants for the RGB window convolution block.
// No dependencies; rgb_window_convolution and rwc_lane refer to this package by scoped name.
package rwc_pkg;

   localparam int PIX_W       = 8;
   localparam int CHANNELS    = 3;
   localparam int COORD_W     = 10;
   localparam int ROW_LIMIT   = 1024;
   localparam int COEFF_REGS  = 5;
   localparam int COEFF_REG_W = 60;
   localparam int DIM_W       = 11;
   localparam int KSIZE_W     = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_KERNEL_SIZE  = 3'd2,
      REG_COEFF_ROW0   = 3'd3,
      REG_COEFF_ROW1   = 3'd4,
      REG_COEFF_ROW2   = 3'd5,
      REG_COEFF_ROW3   = 3'd6,
      REG_COEFF_ROW4   = 3'd7
   } cfg_reg_type;

   // Position and frame marker that follow a request down the pipeline.
   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } meta_type;

endpackage

// ----- rtl/rgb_window_convolution.sv -----
// Top level of the RGB window convolution: config registers, line store, window, lanes, merge.
// Depends on rwc_pkg, rwc_ram and rwc_lane.
//
//  channel  | direction | handshake              | payload
//  req_     | in        | tvalid/tready          | tdata: red, green, blue
//  rsp_     | out       | tvalid/tready          | tdata: red, green, blue, col, row; tlast
//  csr_     | in        | psel/penable/pready    | 64-bit register at 8*index
//
// One request per cycle unless rsp_ stalls; results pass stage 1, window, lanes, merge.
// The pipeline advances as a whole whenever the output register is empty or taken,
// so a stall on rsp_ holds every stage and lowers req_tready in the same cycle.
// Reset clears counters, valid bits and config registers; the line store needs no clearing.
module rgb_window_convolution #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_KERNEL = 5,
   parameter int COEFF_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // red, green, blue
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,  // red, green, blue, out_col, out_row
   output logic                              rsp_tlast,  // frame_last
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rwc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rwc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rwc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int K       = MAX_KERNEL;
   localparam int PIX3_W  = rwc_pkg::PIX_W * rwc_pkg::CHANNELS;
   localparam int COL_AW  = $clog2(MAX_WIDTH);
   localparam int WCMP_W  = ($clog2(MAX_WIDTH + 1) > rwc_pkg::DIM_W) ?
                            $clog2(MAX_WIDTH + 1) : rwc_pkg::DIM_W;
   localparam int SLOT_W  = (K > 1) ? $clog2(K) : 1;
   localparam int SUM_W   = rwc_pkg::PIX_W + COEFF_BITS + $clog2(K * K);
   localparam int RND_W   = SUM_W + 1;

   // ---------------- configuration registers ----------------
   logic [rwc_pkg::DIM_W-1:0]       width_ff, height_ff;
   logic [rwc_pkg::KSIZE_W-1:0]     ksize_ff;
   logic [rwc_pkg::COEFF_REG_W-1:0] coeff_ff [rwc_pkg::COEFF_REGS];
   logic                            cfg_wr;
   rwc_pkg::cfg_reg_type            cfg_idx;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_idx    = rwc_pkg::cfg_reg_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rwc_pkg::DIM_W'(1024);
         height_ff <= rwc_pkg::DIM_W'(1024);
         ksize_ff  <= rwc_pkg::KSIZE_W'(3);
         for (int i = 0; i < rwc_pkg::COEFF_REGS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (cfg_wr) begin
         case (cfg_idx)
            rwc_pkg::REG_IMAGE_WIDTH:  width_ff    <= csr_pwdata[rwc_pkg::DIM_W-1:0];
            rwc_pkg::REG_IMAGE_HEIGHT: height_ff   <= csr_pwdata[rwc_pkg::DIM_W-1:0];
            rwc_pkg::REG_KERNEL_SIZE:  ksize_ff    <= csr_pwdata[rwc_pkg::KSIZE_W-1:0];
            rwc_pkg::REG_COEFF_ROW0:   coeff_ff[0] <= csr_pwdata[rwc_pkg::COEFF_REG_W-1:0];
            rwc_pkg::REG_COEFF_ROW1:   coeff_ff[1] <= csr_pwdata[rwc_pkg::COEFF_REG_W-1:0];
            rwc_pkg::REG_COEFF_ROW2:   coeff_ff[2] <= csr_pwdata[rwc_pkg::COEFF_REG_W-1:0];
            rwc_pkg::REG_COEFF_ROW3:   coeff_ff[3] <= csr_pwdata[rwc_pkg::COEFF_REG_W-1:0];
            rwc_pkg::REG_COEFF_ROW4:   coeff_ff[4] <= csr_pwdata[rwc_pkg::COEFF_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         rwc_pkg::REG_IMAGE_WIDTH:  csr_prdata = rwc_pkg::CSR_DATA_W'(width_ff);
         rwc_pkg::REG_IMAGE_HEIGHT: csr_prdata = rwc_pkg::CSR_DATA_W'(height_ff);
         rwc_pkg::REG_KERNEL_SIZE:  csr_prdata = rwc_pkg::CSR_DATA_W'(ksize_ff);
         rwc_pkg::REG_COEFF_ROW0:   csr_prdata = rwc_pkg::CSR_DATA_W'(coeff_ff[0]);
         rwc_pkg::REG_COEFF_ROW1:   csr_prdata = rwc_pkg::CSR_DATA_W'(coeff_ff[1]);
         rwc_pkg::REG_COEFF_ROW2:   csr_prdata = rwc_pkg::CSR_DATA_W'(coeff_ff[2]);
         rwc_pkg::REG_COEFF_ROW3:   csr_prdata = rwc_pkg::CSR_DATA_W'(coeff_ff[3]);
         rwc_pkg::REG_COEFF_ROW4:   csr_prdata = rwc_pkg::CSR_DATA_W'(coeff_ff[4]);
         default:                   csr_prdata = '0;
      endcase
   end

   // Clamp sizes to their legal ranges.
   logic [WCMP_W-1:0]            w_eff;
   logic [rwc_pkg::DIM_W-1:0]    h_eff;
   logic [rwc_pkg::KSIZE_W-1:0]  k_eff;

   always_comb begin
      if (width_ff == '0) w_eff = WCMP_W'(1);
      else if (WCMP_W'(width_ff) > WCMP_W'(MAX_WIDTH)) w_eff = WCMP_W'(MAX_WIDTH);
      else w_eff = WCMP_W'(width_ff);
      if (height_ff == '0) h_eff = rwc_pkg::DIM_W'(1);
      else if (height_ff > rwc_pkg::DIM_W'(rwc_pkg::ROW_LIMIT))
         h_eff = rwc_pkg::DIM_W'(rwc_pkg::ROW_LIMIT);
      else h_eff = height_ff;
      if (ksize_ff == '0) k_eff = rwc_pkg::KSIZE_W'(1);
      else if (ksize_ff > rwc_pkg::KSIZE_W'(K)) k_eff = rwc_pkg::KSIZE_W'(K);
      else k_eff = ksize_ff;
   end

   // Coefficient grid in kernel coordinates; fields past bit 63 or past row four weigh zero.
   logic [COEFF_BITS-1:0] coeff_mat [K][K];

   for (genvar r = 0; r < K; r++) begin : g_crow
      for (genvar c = 0; c < K; c++) begin : g_ccol
         if (r < rwc_pkg::COEFF_REGS && c * COEFF_BITS < 64) begin : g_live
            logic [63:0] wide;
            assign wide = 64'(coeff_ff[r]) >> (c * COEFF_BITS);
            assign coeff_mat[r][c] = wide[COEFF_BITS-1:0];
         end else begin : g_zero
            assign coeff_mat[r][c] = '0;
         end
      end
   end

   // Window tap (age a, column offset p) weighs kernel entry (k-1-a, k-1-p).
   logic [K*K-1:0][COEFF_BITS-1:0] coeff_tap;

   always_comb begin
      for (int a = 0; a < K; a++) begin
         for (int p = 0; p < K; p++) begin
            coeff_tap[a*K+p] = '0;
            for (int kk = 1; kk <= K; kk++) begin
               if (k_eff == rwc_pkg::KSIZE_W'(kk) && a < kk && p < kk) begin
                  coeff_tap[a*K+p] = coeff_mat[kk-1-a][kk-1-p];
               end
            end
         end
      end
   end

   // ---------------- input stage: counters and line store ----------------
   logic                         en, accept;
   logic [rwc_pkg::COORD_W-1:0]  col_ff, row_ff, col_in, row_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [WCMP_W-1:0]            col_ext;
   logic                         end_line, end_frame, emit;
   rwc_pkg::meta_type            meta_cur;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;
   assign col_ext    = WCMP_W'(col_ff);
   assign end_line   = (col_ext + WCMP_W'(1)) >= w_eff;
   assign end_frame  = end_line &&
                       ((rwc_pkg::DIM_W'(row_ff) + rwc_pkg::DIM_W'(1)) >= h_eff);
   assign emit       = ((col_ext + WCMP_W'(1)) >= WCMP_W'(k_eff)) &&
                       ((rwc_pkg::DIM_W'(row_ff) + rwc_pkg::DIM_W'(1)) >=
                        rwc_pkg::DIM_W'(k_eff)) &&
                       (col_ext < WCMP_W'(MAX_WIDTH));

   assign meta_cur.col  = col_ff + rwc_pkg::COORD_W'(1) - rwc_pkg::COORD_W'(k_eff);
   assign meta_cur.row  = row_ff + rwc_pkg::COORD_W'(1) - rwc_pkg::COORD_W'(k_eff);
   assign meta_cur.last = end_frame;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (end_line) begin
            col_in = '0;
            if (end_frame) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + rwc_pkg::COORD_W'(1);
               slot_in = (slot_ff == SLOT_W'(K - 1)) ? '0 : slot_ff + SLOT_W'(1);
            end
         end else begin
            col_in = col_ff + rwc_pkg::COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   logic [PIX3_W-1:0] rd_data [K];

   for (genvar s = 0; s < K; s++) begin : g_line
      rwc_ram #(
         .WIDTH(PIX3_W),
         .DEPTH(MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (accept && slot_ff == SLOT_W'(s) && col_ext < WCMP_W'(MAX_WIDTH)),
         .wr_addr (col_ext[COL_AW-1:0]),
         .wr_data (req_tdata),
         .rd_en   (accept),
         .rd_addr (col_ext[COL_AW-1:0]),
         .rd_data (rd_data[s])
      );
   end

   // ---------------- stage 1: line store read ----------------
   logic                 s1_valid_ff, s1_emit_ff;
   rwc_pkg::meta_type    s1_meta_ff;
   logic [SLOT_W-1:0]    s1_slot_ff;
   logic [PIX3_W-1:0]    s1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit;
         s1_meta_ff <= meta_cur;
         s1_slot_ff <= slot_ff;
         s1_pix_ff  <= req_tdata;
      end
   end

   // New window column ordered by age: age 0 is the current line.
   logic [PIX3_W-1:0] new_col [K];
   logic [SLOT_W:0]   slot_sum;

   always_comb begin
      slot_sum = '0;
      for (int a = 0; a < K; a++) begin
         if (a == 0) begin
            new_col[a] = s1_pix_ff;
         end else begin
            slot_sum = (SLOT_W + 1)'(s1_slot_ff) + (SLOT_W + 1)'(K - a);
            if (slot_sum >= (SLOT_W + 1)'(K)) slot_sum = slot_sum - (SLOT_W + 1)'(K);
            new_col[a] = rd_data[slot_sum[SLOT_W-1:0]];
         end
      end
   end

   // ---------------- window stage ----------------
   logic [PIX3_W-1:0]  win_ff [K][K];
   logic               w_valid_ff;
   rwc_pkg::meta_type  w_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else if (en) begin
         w_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         w_meta_ff <= s1_meta_ff;
         for (int a = 0; a < K; a++) begin
            win_ff[a][0] <= new_col[a];
            for (int p = 1; p < K; p++) begin
               win_ff[a][p] <= win_ff[a][p-1];
            end
         end
      end
   end

   // ---------------- channel lanes ----------------
   logic [K*K-1:0][rwc_pkg::PIX_W-1:0] lane_pix [rwc_pkg::CHANNELS];
   logic [SUM_W-1:0]                   lane_sum [rwc_pkg::CHANNELS];

   for (genvar ch = 0; ch < rwc_pkg::CHANNELS; ch++) begin : g_lane
      // Drop taps outside the kernel so stale or unwritten window entries never reach a sum.
      always_comb begin
         for (int a = 0; a < K; a++) begin
            for (int p = 0; p < K; p++) begin
               if (a < int'(k_eff) && p < int'(k_eff)) begin
                  lane_pix[ch][a*K+p] = win_ff[a][p][ch*rwc_pkg::PIX_W +: rwc_pkg::PIX_W];
               end else begin
                  lane_pix[ch][a*K+p] = '0;
               end
            end
         end
      end

      rwc_lane #(
         .MAX_KERNEL(K),
         .COEFF_BITS(COEFF_BITS)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .pix   (lane_pix[ch]),
         .coeff (coeff_tap),
         .sum   (lane_sum[ch])
      );
   end

   // Metadata rides alongside the three lane stages.
   logic [2:0]         lv_valid_ff;
   rwc_pkg::meta_type  lv_meta_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_valid_ff <= '0;
      end else if (en) begin
         lv_valid_ff <= {lv_valid_ff[1:0], w_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lv_meta_ff[0] <= w_meta_ff;
         lv_meta_ff[1] <= lv_meta_ff[0];
         lv_meta_ff[2] <= lv_meta_ff[1];
      end
   end

   // ---------------- merge: round, saturate, output register ----------------
   logic [rwc_pkg::PIX_W-1:0] chan_out [rwc_pkg::CHANNELS];
   logic [RND_W-1:0]          rnd [rwc_pkg::CHANNELS];

   always_comb begin
      for (int ch = 0; ch < rwc_pkg::CHANNELS; ch++) begin
         rnd[ch] = (RND_W'(lane_sum[ch]) + RND_W'(1 << (COEFF_BITS - 1))) >> COEFF_BITS;
         if (rnd[ch] > RND_W'(255)) chan_out[ch] = 8'hFF;
         else chan_out[ch] = rnd[ch][rwc_pkg::PIX_W-1:0];
      end
   end

   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lv_valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en && lv_valid_ff[2]) begin
         rsp_data_ff <= {4'b0, lv_meta_ff[2].row, lv_meta_ff[2].col,
                         chan_out[2], chan_out[1], chan_out[0]};
         rsp_last_ff <= lv_meta_ff[2].last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(K - 1))
      else $error("line slot out of range");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && end_frame |=> col_ff == '0 && row_ff == '0 && slot_ff == '0)
      else $error("counters did not wrap at frame end");

   a_row_slot: assert property (@(posedge clock) disable iff (reset)
      row_ff == '0 |-> slot_ff == '0)
      else $error("line slot out of step with row");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(col_ff) && $stable(lv_valid_ff))
      else $error("pipeline moved during stall");

endmodule

// ----- rtl/rwc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line store of the window convolution.
module rwc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rwc_lane.sv -----
// One color lane: multiplies the window by the kernel, then sums over two stages.
// Depends on rwc_pkg for the pixel width.
module rwc_lane #(
   parameter int MAX_KERNEL = 5,
   parameter int COEFF_BITS = 12
) (
   input  logic                                                   clock,
   input  logic                                                   en,
   input  logic [MAX_KERNEL*MAX_KERNEL-1:0][rwc_pkg::PIX_W-1:0]   pix,
   input  logic [MAX_KERNEL*MAX_KERNEL-1:0][COEFF_BITS-1:0]       coeff,
   output logic [rwc_pkg::PIX_W+COEFF_BITS+$clog2(MAX_KERNEL*MAX_KERNEL)-1:0] sum
);

   localparam int PROD_W = rwc_pkg::PIX_W + COEFF_BITS;
   localparam int ROW_W  = PROD_W + $clog2(MAX_KERNEL + 1);
   localparam int SUM_W  = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL);
   localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;

   logic [PROD_W-1:0] prod_ff [TAPS];
   logic [ROW_W-1:0]  row_ff  [MAX_KERNEL];
   logic [SUM_W-1:0]  sum_ff;
   logic [ROW_W-1:0]  row_in  [MAX_KERNEL];
   logic [SUM_W-1:0]  sum_in;

   always_comb begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
         row_in[r] = '0;
         for (int c = 0; c < MAX_KERNEL; c++) begin
            row_in[r] = row_in[r] + ROW_W'(prod_ff[r*MAX_KERNEL+c]);
         end
      end
      sum_in = '0;
      for (int r = 0; r < MAX_KERNEL; r++) begin
         sum_in = sum_in + SUM_W'(row_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < TAPS; i++) begin
            prod_ff[i] <= PROD_W'(pix[i]) * PROD_W'(coeff[i]);
         end
         for (int r = 0; r < MAX_KERNEL; r++) begin
            row_ff[r] <= row_in[r];
         end
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ----- bench/rgb_window_convolution_tb.sv -----
// Testbench for rgb_window_convolution: frames of RGB pixels against a behavioral predictor.
// Depends on rwc_pkg and the rgb_window_convolution RTL; needs no files or arguments.
`timescale 1ns / 1ps

module rgb_window_convolution_tb;

   localparam int LINES      = 5;
   localparam int LINE_LEN   = 1024;
   localparam int ITEM_GOAL  = 1600;
   localparam int DRAIN_WAIT = 12;

   // coefficient fill patterns for a phase
   localparam int COEF_ZERO   = 0;
   localparam int COEF_FULL   = 1;
   localparam int COEF_CORNER = 2;
   localparam int COEF_RANDOM = 3;
   localparam int NO_VALUE    = -1;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [9:0] col;
      logic [9:0] row;
      logic       last;
   } conv_result_type;

   typedef struct {
      int width;
      int height;
      int ksize;
      int coef_mode;
      int pixel;     // fixed 24-bit pixel, or NO_VALUE for random
      int channels;  // channels known by hand, or NO_VALUE
   } frame_plan_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // red, green, blue, out_col, out_row
   logic        rsp_tlast;   // frame_last
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [rwc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rwc_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rwc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [10:0] cfg_width;
   logic [10:0] cfg_height;
   logic [2:0]  cfg_ksize;
   logic [59:0] cfg_coeff [rwc_pkg::COEFF_REGS];
   logic [23:0] line_mem [LINES][LINE_LEN];
   logic [9:0]  next_col;
   logic [9:0]  next_row;

   conv_result_type filtered_q[$];
   int  mismatches;
   int  pixels_sent;
   bit  no_idle;

   frame_plan_type directed_frames[6] = '{
      '{1, 1, 1, COEF_CORNER, 24'hFF00FF, 24'hFF00FF},
      '{1, 1, 0, COEF_FULL,   24'h00FF00, 24'h00FF00},
      '{3, 3, 3, COEF_FULL,   24'hFFFFFF, 24'hFFFFFF},
      '{2, 2, 7, COEF_RANDOM, NO_VALUE,   NO_VALUE},
      '{0, 0, 1, COEF_ZERO,   24'hFFFFFF, 24'h000000},
      '{4, 2, 2, COEF_RANDOM, NO_VALUE,   NO_VALUE}
   };

   rgb_window_convolution DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   function automatic int clamp_dim(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the predictor by one pixel; return 1 when it yields a result.
   function automatic bit convolve_pixel(logic [23:0] pix, output conv_result_type res);
      int w, h, k, c0, r0, coef, px;
      logic [31:0] acc;
      bit end_line, end_frame, hit;
      w = clamp_dim(cfg_width, LINE_LEN);
      h = clamp_dim(cfg_height, rwc_pkg::ROW_LIMIT);
      k = clamp_dim(cfg_ksize, 5);
      end_line = (next_col + 1 >= w);
      end_frame = end_line && (next_row + 1 >= h);
      line_mem[next_row % LINES][next_col] = pix;
      hit = (next_col + 1 >= k) && (next_row + 1 >= k);
      res = '{default: '0};
      if (hit) begin
         c0 = next_col + 1 - k;
         r0 = next_row + 1 - k;
         for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int r = 0; r < k; r++)
               for (int c = 0; c < k; c++) begin
                  coef = cfg_coeff[r][c*12 +: 12];
                  px = line_mem[(r0 + r) % LINES][c0 + c][ch*8 +: 8];
                  acc += coef * px;
               end
            acc = (acc + 2048) >> 12;
            if (acc > 255) acc = 255;
            case (ch)
               0: res.red = acc[7:0];
               1: res.green = acc[7:0];
               default: res.blue = acc[7:0];
            endcase
         end
         res.col = c0[9:0];
         res.row = r0[9:0];
         res.last = end_frame;
      end
      if (end_line) begin
         next_col = '0;
         next_row = end_frame ? 10'd0 : next_row + 10'd1;
      end else begin
         next_col = next_col + 10'd1;
      end
      return hit;
   endfunction

   task automatic write_reg(rwc_pkg::cfg_reg_type idx, logic [63:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      case (idx)
         rwc_pkg::REG_IMAGE_WIDTH:  cfg_width = value[10:0];
         rwc_pkg::REG_IMAGE_HEIGHT: cfg_height = value[10:0];
         rwc_pkg::REG_KERNEL_SIZE:  cfg_ksize = value[2:0];
         default:                   cfg_coeff[idx - rwc_pkg::REG_COEFF_ROW0] = value[59:0];
      endcase
   endtask

   function automatic logic [63:0] coeff_word(int mode, int r);
      logic [63:0] word;
      int shift;
      word = '0;
      case (mode)
         COEF_FULL:   word = '1;
         COEF_CORNER: word = (r == 0) ? 64'hFFF : 64'h0;
         COEF_RANDOM: begin
            // scale taps down often so that sums do not always saturate
            shift = $urandom_range(0, 6);
            for (int c = 0; c < 5; c++)
               word[c*12 +: 12] = 12'($urandom_range(0, 4095) >> shift);
            word[63:60] = 4'($urandom_range(0, 15));
         end
         default: word = '0;
      endcase
      return word;
   endfunction

   task automatic wait_idle();
      while (filtered_q.size() != 0) @(negedge clock);
      // frames whose last pixels give no result may still be in flight
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic send_pixel(logic [23:0] pix, int channels);
      conv_result_type res;
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = pix;
      do @(posedge clock); while (!req_tready);
      if (convolve_pixel(pix, res)) begin
         if (channels != NO_VALUE) begin
            res.red = channels[7:0];
            res.green = channels[15:8];
            res.blue = channels[23:16];
         end
         filtered_q.push_back(res);
      end
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic run_frame(frame_plan_type plan);
      int w, h;
      logic [23:0] pix;
      wait_idle();
      write_reg(rwc_pkg::REG_IMAGE_WIDTH, plan.width);
      write_reg(rwc_pkg::REG_IMAGE_HEIGHT, plan.height);
      write_reg(rwc_pkg::REG_KERNEL_SIZE, plan.ksize);
      for (int r = 0; r < rwc_pkg::COEFF_REGS; r++)
         write_reg(rwc_pkg::cfg_reg_type'(rwc_pkg::REG_COEFF_ROW0 + r),
                   coeff_word(plan.coef_mode, r));
      w = clamp_dim(plan.width, LINE_LEN);
      h = clamp_dim(plan.height, rwc_pkg::ROW_LIMIT);
      for (int i = 0; i < w * h; i++) begin
         if (plan.pixel != NO_VALUE) pix = plan.pixel[23:0];
         else case ($urandom_range(0, 9))
            0: pix = '0;
            1: pix = '1;
            default: pix = 24'($urandom);
         endcase
         send_pixel(pix, plan.channels);
      end
      req_tvalid = 1'b0;
   endtask

   // result side: draw a stall per result
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = filtered_q.pop_front();
            if (rsp_tdata[7:0] !== want.red || rsp_tdata[15:8] !== want.green ||
                rsp_tdata[23:16] !== want.blue || rsp_tdata[33:24] !== want.col ||
                rsp_tdata[43:34] !== want.row || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp rgb %h %h %h col %0d row %0d last %b, got %h last %b",
                           want.red, want.green, want.blue, want.col, want.row, want.last,
                           rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   initial begin
      frame_plan_type plan;
      mismatches = 0;
      pixels_sent = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_width = 11'd1024;
      cfg_height = 11'd1024;
      cfg_ksize = 3'd3;
      for (int r = 0; r < rwc_pkg::COEFF_REGS; r++) cfg_coeff[r] = '0;
      next_col = '0;
      next_row = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      foreach (directed_frames[i]) run_frame(directed_frames[i]);

      // extremes: an over-wide line held to 1024 pixels, zero height and zero kernel size
      run_frame('{2047, 0, 0, COEF_RANDOM, NO_VALUE, NO_VALUE});

      while (pixels_sent < ITEM_GOAL) begin
         no_idle = ($urandom_range(0, 3) == 0);
         plan.width = $urandom_range(0, 12);
         plan.height = $urandom_range(0, 8);
         plan.ksize = $urandom_range(0, 7);
         plan.coef_mode = ($urandom_range(0, 7) == 0) ? COEF_FULL : COEF_RANDOM;
         plan.pixel = NO_VALUE;
         plan.channels = NO_VALUE;
         run_frame(plan);
      end

      no_idle = 1'b0;
      wait_idle();
      if (mismatches == 0 && filtered_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
